### sv/fdmc_pkg.sv
// ----------------------------------------------------------------------------
// fdmc_pkg
// Shared types, constants and helpers of the frame difference motion counter.
// ----------------------------------------------------------------------------
package fdmc_pkg;

    localparam int PIX_W        = 8;
    localparam int TALLY_W      = 14;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;
    localparam int FIFO_DEPTH   = 3;

    localparam int DEF_SRC_WIDTH  = 160;
    localparam int DEF_SRC_HEIGHT = 120;
    localparam int DEF_DST_WIDTH  = 96;
    localparam int DEF_DST_HEIGHT = 96;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE       = 1'd1;

    typedef enum logic {
        KIND_MARK    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    // scan stage decision for one accepted pixel
    typedef struct packed {
        logic kept;
        logic last;
        logic start;
    } scan_t;

    // one result item
    typedef struct packed {
        kind_t              kind;
        logic               mark;
        logic [TALLY_W-1:0] count;
        logic               flag;
    } res_t;

    // bits needed to index n entries, at least one
    function automatic int addr_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

### sv/fdmc_pix_if.sv
// ----------------------------------------------------------------------------
// fdmc_pix_if
// Camera pixel channel: valid/ready handshake with one grayscale pixel.
// ----------------------------------------------------------------------------
interface fdmc_pix_if;
    logic                        valid;
    logic                        ready;
    logic [fdmc_pkg::PIX_W-1:0]  pixel_value;
    logic                        frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

### sv/fdmc_res_if.sv
// ----------------------------------------------------------------------------
// fdmc_res_if
// Result channel: per-pixel motion mark or end-of-frame summary.
// ----------------------------------------------------------------------------
interface fdmc_res_if;
    logic                          valid;
    logic                          ready;
    logic                          result_kind;
    logic                          pixel_mark;
    logic [fdmc_pkg::TALLY_W-1:0]  motion_count;
    logic                          motion_flag;

    modport source (output valid, output result_kind, output pixel_mark,
                    output motion_count, output motion_flag, input ready);
    modport sink   (input valid, input result_kind, input pixel_mark,
                    input motion_count, input motion_flag, output ready);
endinterface

### sv/frame_difference_motion_counter.sv
// ----------------------------------------------------------------------------
// frame_difference_motion_counter
// Downsamples a raster pixel stream, compares each kept pixel with the stored
// previous frame, and reports per-pixel motion marks in raw mode and a per-frame count.
//
//   channel   dir   handshake      payload
//   pixels    in    valid/ready    pixel_value[7:0], frame_start
//   results   out   valid/ready    result_kind, pixel_mark,
//                                  motion_count[13:0], motion_flag
//   cfg       in    cfg_wr_en      cfg_index[0], cfg_data[7:0]
//
// One pixel per cycle while pixel ready is high. A pixel is scanned and its
// store read issued at acceptance; the next cycle compares against the read
// data and writes back. A result from the compare stage waits in a 3-entry queue.
// After reset the store zero-fills all DST_WIDTH*DST_HEIGHT entries
// (9216 by default) while pixel ready stays low.
// Pixel ready drops when the queue cannot absorb the pixel in flight.
// ----------------------------------------------------------------------------
module frame_difference_motion_counter #(
    parameter int SRC_WIDTH  = fdmc_pkg::DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT = fdmc_pkg::DEF_SRC_HEIGHT,
    parameter int DST_WIDTH  = fdmc_pkg::DEF_DST_WIDTH,
    parameter int DST_HEIGHT = fdmc_pkg::DEF_DST_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [fdmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fdmc_pkg::CFG_DATA_W-1:0]     cfg_data,
    fdmc_pix_if.sink                            pixels,
    fdmc_res_if.source                          results
);

    localparam int DEPTH = DST_WIDTH * DST_HEIGHT;
    localparam int AW    = fdmc_pkg::addr_bits(DEPTH);

    logic [fdmc_pkg::PIX_W-1:0]   thr_reg;
    logic                         raw_reg;

    fdmc_pkg::scan_t              scan;
    logic [AW-1:0]                scan_addr;
    logic                         accept;
    logic                         store_ready;
    logic [1:0]                   fifo_level;

    logic                         s1_valid_reg;
    fdmc_pkg::scan_t              s1_scan_reg;
    logic [AW-1:0]                s1_addr_reg;
    logic [fdmc_pkg::PIX_W-1:0]   s1_pix_reg;

    logic [fdmc_pkg::PIX_W-1:0]   old_pix;
    logic [fdmc_pkg::PIX_W-1:0]   diff;
    logic                         mark;
    logic [fdmc_pkg::TALLY_W-1:0] tally_reg, tally_next;
    logic [fdmc_pkg::TALLY_W-1:0] tally_base, tally_new;
    logic                         s1_push;
    fdmc_pkg::res_t               s1_res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
            raw_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fdmc_pkg::REG_DIFF_THRESHOLD: thr_reg <= cfg_data;
                fdmc_pkg::REG_RAW_MODE:       raw_reg <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    // hold requests while clearing or while the queue may overflow
    assign pixels.ready = store_ready && ({1'b0, fifo_level} + {2'b0, s1_valid_reg} <= 3'd2);
    assign accept       = pixels.valid & pixels.ready;

    fdmc_scan #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .DST_WIDTH  (DST_WIDTH),
        .DST_HEIGHT (DST_HEIGHT)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .frame_start (pixels.frame_start),
        .scan        (scan),
        .addr        (scan_addr)
    );

    fdmc_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept & scan.kept),
        .rd_addr (scan_addr),
        .wr_en   (s1_valid_reg & s1_scan_reg.kept),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pix_reg),
        .rd_data (old_pix),
        .ready   (store_ready)
    );

    // compare stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            tally_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            tally_reg    <= tally_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_scan_reg <= scan;
            s1_addr_reg <= scan_addr;
            s1_pix_reg  <= pixels.pixel_value;
        end
    end

    always_comb
    begin
        diff       = (s1_pix_reg > old_pix) ? (s1_pix_reg - old_pix) : (old_pix - s1_pix_reg);
        mark       = (diff > thr_reg);
        tally_base = s1_scan_reg.start ? '0 : tally_reg;
        tally_new  = tally_base;
        if (s1_scan_reg.kept && !raw_reg && mark && (tally_base != fdmc_pkg::TALLY_MAX))
        begin
            tally_new = tally_base + 1'b1;
        end

        tally_next = tally_reg;
        if (s1_valid_reg)
        begin
            tally_next = s1_scan_reg.last ? '0 : tally_new;
        end

        s1_push = s1_valid_reg && (s1_scan_reg.last || (s1_scan_reg.kept && raw_reg));
        if (s1_scan_reg.last)
        begin
            s1_res.kind  = fdmc_pkg::KIND_SUMMARY;
            s1_res.mark  = 1'b0;
            s1_res.count = tally_new;
            s1_res.flag  = (tally_new > fdmc_pkg::TALLY_W'(thr_reg));
        end
        else
        begin
            s1_res.kind  = fdmc_pkg::KIND_MARK;
            s1_res.mark  = mark;
            s1_res.count = '0;
            s1_res.flag  = 1'b0;
        end
    end

    fdmc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_push),
        .push_data (s1_res),
        .level     (fifo_level),
        .deq       (results)
    );

    // queue never takes a result while full and not draining
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_push |-> (fifo_level != 2'd3 || results.ready))
        else $error("result queue overflow");

    // no pixel write-back while the store is still being cleared
    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !store_ready |-> !(s1_valid_reg && s1_scan_reg.kept))
        else $error("store written during clear sweep");

    // tally restarts after every frame summary
    a_tally_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_scan_reg.last) |=> (tally_reg == '0))
        else $error("tally not cleared after summary");

    // per-pixel marks only come out in raw mode
    a_mark_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_push && !s1_scan_reg.last) |-> raw_reg)
        else $error("pixel mark produced in count mode");

endmodule

### sv/fdmc_store.sv
// ----------------------------------------------------------------------------
// fdmc_store
// Previous-frame pixel memory: one write and one registered read per cycle,
// write-to-read forwarding, and a zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module fdmc_store #(
    parameter int DEPTH = fdmc_pkg::DEF_DST_WIDTH * fdmc_pkg::DEF_DST_HEIGHT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   rd_en,
    input  logic [fdmc_pkg::addr_bits(DEPTH)-1:0]  rd_addr,
    input  logic                                   wr_en,
    input  logic [fdmc_pkg::addr_bits(DEPTH)-1:0]  wr_addr,
    input  logic [fdmc_pkg::PIX_W-1:0]             wr_data,
    output logic [fdmc_pkg::PIX_W-1:0]             rd_data,
    output logic                                   ready
);

    localparam int AW = fdmc_pkg::addr_bits(DEPTH);

    logic [fdmc_pkg::PIX_W-1:0] ram [DEPTH];

    logic                       clr_busy_reg, clr_busy_next;
    logic [AW-1:0]              clr_addr_reg, clr_addr_next;
    logic [fdmc_pkg::PIX_W-1:0] rd_data_reg;
    logic                       fwd_hit_reg;
    logic [fdmc_pkg::PIX_W-1:0] fwd_data_reg;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [fdmc_pkg::PIX_W-1:0] mem_wdata;

    always_comb
    begin
        mem_we    = clr_busy_reg | wr_en;
        mem_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
        mem_wdata = clr_busy_reg ? '0 : wr_data;
    end

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            // a read of the entry written at the same edge sees the new value
            fwd_hit_reg  <= rd_en & wr_en & (rd_addr == wr_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ram[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= ram[rd_addr];
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign ready   = ~clr_busy_reg;

endmodule

### sv/fdmc_scan.sv
// ----------------------------------------------------------------------------
// fdmc_scan
// Raster position tracker: follows source and target coordinates, decides
// which source pixels the nearest-neighbour downsampler keeps, and forms the
// store address of each kept pixel.
// ----------------------------------------------------------------------------
module fdmc_scan #(
    parameter int SRC_WIDTH  = fdmc_pkg::DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT = fdmc_pkg::DEF_SRC_HEIGHT,
    parameter int DST_WIDTH  = fdmc_pkg::DEF_DST_WIDTH,
    parameter int DST_HEIGHT = fdmc_pkg::DEF_DST_HEIGHT
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  advance,
    input  logic                                                  frame_start,
    output fdmc_pkg::scan_t                                       scan,
    output logic [fdmc_pkg::addr_bits(DST_WIDTH*DST_HEIGHT)-1:0]  addr
);

    localparam int AW  = fdmc_pkg::addr_bits(DST_WIDTH * DST_HEIGHT);
    localparam int SCW = fdmc_pkg::addr_bits(SRC_WIDTH);
    localparam int SRW = fdmc_pkg::addr_bits(SRC_HEIGHT);
    localparam int TCW = $clog2(DST_WIDTH + 1);
    localparam int TRW = $clog2(DST_HEIGHT + 1);
    localparam int QCW = $clog2(SRC_WIDTH + 1);
    localparam int QRW = $clog2(SRC_HEIGHT + 1);
    localparam int RCW = $clog2(2 * DST_WIDTH);
    localparam int RRW = $clog2(2 * DST_HEIGHT);
    localparam int BW  = $clog2(DST_WIDTH * DST_HEIGHT + 1);

    localparam int COL_Q = SRC_WIDTH / DST_WIDTH;
    localparam int COL_R = SRC_WIDTH % DST_WIDTH;
    localparam int ROW_Q = SRC_HEIGHT / DST_HEIGHT;
    localparam int ROW_R = SRC_HEIGHT % DST_HEIGHT;

    // qc/rc hold target_column*SRC_WIDTH/DST_WIDTH as quotient and remainder
    logic [SCW-1:0] sc_reg, sc_next, sc_e;
    logic [SRW-1:0] sr_reg, sr_next, sr_e;
    logic [TCW-1:0] tc_reg, tc_next, tc_e;
    logic [TRW-1:0] tr_reg, tr_next, tr_e;
    logic [QCW-1:0] qc_reg, qc_next, qc_e;
    logic [RCW-1:0] rc_reg, rc_next, rc_e;
    logic [QRW-1:0] qr_reg, qr_next, qr_e;
    logic [RRW-1:0] rr_reg, rr_next, rr_e;
    logic [BW-1:0]  base_reg, base_next, base_e;

    logic           row_kept;
    logic           col_end;
    logic [RCW-1:0] rc_sum;
    logic [RRW-1:0] rr_sum;

    always_comb
    begin
        sc_e   = frame_start ? '0 : sc_reg;
        sr_e   = frame_start ? '0 : sr_reg;
        tc_e   = frame_start ? '0 : tc_reg;
        tr_e   = frame_start ? '0 : tr_reg;
        qc_e   = frame_start ? '0 : qc_reg;
        rc_e   = frame_start ? '0 : rc_reg;
        qr_e   = frame_start ? '0 : qr_reg;
        rr_e   = frame_start ? '0 : rr_reg;
        base_e = frame_start ? '0 : base_reg;
    end

    always_comb
    begin
        row_kept   = (tr_e < TRW'(DST_HEIGHT)) && (qr_e <= QRW'(sr_e));
        scan.kept  = row_kept && (tc_e < TCW'(DST_WIDTH)) && (qc_e <= QCW'(sc_e));
        col_end    = (sc_e == SCW'(SRC_WIDTH - 1));
        scan.last  = col_end && (sr_e == SRW'(SRC_HEIGHT - 1));
        scan.start = frame_start;
        addr       = AW'(base_e + BW'(tc_e));
        rc_sum     = rc_e + RCW'(COL_R);
        rr_sum     = rr_e + RRW'(ROW_R);
    end

    always_comb
    begin
        sc_next   = sc_e;
        sr_next   = sr_e;
        tc_next   = tc_e;
        tr_next   = tr_e;
        qc_next   = qc_e;
        rc_next   = rc_e;
        qr_next   = qr_e;
        rr_next   = rr_e;
        base_next = base_e;

        if (scan.kept)
        begin
            tc_next = tc_e + 1'b1;
            if (rc_sum >= RCW'(DST_WIDTH))
            begin
                rc_next = rc_sum - RCW'(DST_WIDTH);
                qc_next = qc_e + QCW'(COL_Q + 1);
            end
            else
            begin
                rc_next = rc_sum;
                qc_next = qc_e + QCW'(COL_Q);
            end
        end

        if (col_end)
        begin
            sc_next = '0;
            tc_next = '0;
            qc_next = '0;
            rc_next = '0;
            if (row_kept)
            begin
                tr_next   = tr_e + 1'b1;
                base_next = base_e + BW'(DST_WIDTH);
                if (rr_sum >= RRW'(DST_HEIGHT))
                begin
                    rr_next = rr_sum - RRW'(DST_HEIGHT);
                    qr_next = qr_e + QRW'(ROW_Q + 1);
                end
                else
                begin
                    rr_next = rr_sum;
                    qr_next = qr_e + QRW'(ROW_Q);
                end
            end
            if (scan.last)
            begin
                // wrap to the top of the next frame
                sr_next   = '0;
                tr_next   = '0;
                qr_next   = '0;
                rr_next   = '0;
                base_next = '0;
            end
            else
            begin
                sr_next = sr_e + 1'b1;
            end
        end
        else
        begin
            sc_next = sc_e + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg   <= '0;
            sr_reg   <= '0;
            tc_reg   <= '0;
            tr_reg   <= '0;
            qc_reg   <= '0;
            rc_reg   <= '0;
            qr_reg   <= '0;
            rr_reg   <= '0;
            base_reg <= '0;
        end
        else if (advance)
        begin
            sc_reg   <= sc_next;
            sr_reg   <= sr_next;
            tc_reg   <= tc_next;
            tr_reg   <= tr_next;
            qc_reg   <= qc_next;
            rc_reg   <= rc_next;
            qr_reg   <= qr_next;
            rr_reg   <= rr_next;
            base_reg <= base_next;
        end
    end

endmodule

### sv/fdmc_out_fifo.sv
// ----------------------------------------------------------------------------
// fdmc_out_fifo
// Three-entry result queue that drives the result channel.
// ----------------------------------------------------------------------------
module fdmc_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fdmc_pkg::res_t      push_data,
    output logic [1:0]          level,
    fdmc_res_if.source          deq
);

    localparam int PW = fdmc_pkg::addr_bits(fdmc_pkg::FIFO_DEPTH);

    fdmc_pkg::res_t entries_reg [fdmc_pkg::FIFO_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [1:0]     level_reg, level_next;
    logic           pop;
    fdmc_pkg::res_t head;

    assign pop  = deq.valid & deq.ready;
    assign head = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(fdmc_pkg::FIFO_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(fdmc_pkg::FIFO_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        deq.valid        = (level_reg != 2'd0);
        deq.result_kind  = head.kind;
        deq.pixel_mark   = head.mark;
        deq.motion_count = head.count;
        deq.motion_flag  = head.flag;
    end

    assign level = level_reg;

endmodule
